// ----- rtl/core/uart_bsf_pkg.sv -----
package uart_bsf_pkg;

   localparam int TX_DEPTH_DEFAULT = 256;
   localparam int RX_DEPTH_DEFAULT = 16;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   localparam logic [1:0] KIND_HOST_WRITE = 2'd0;
   localparam logic [1:0] KIND_HOST_READ  = 2'd1;
   localparam logic [1:0] KIND_LINE_RECV  = 2'd2;
   localparam logic [1:0] KIND_TX_READY   = 2'd3;

   typedef logic [7:0] byte_type;

endpackage

// ----- rtl/core/uart_buffered_stream_fifos_core.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_kind, req_data
// rsp_      out        rsp_valid / rsp_stall  line_tx, read, write_dropped, rx_nonempty,
//                                             overrun_seen
// csr_      in         csr_write_enable       csr_write_data (echo_enable)
//
// Each request beat yields one response beat. A plain host write, or a receive without
// a newline echo, finishes when accepted; a newline write or newline echo makes two
// transmit memory writes (CR, then LF); a host read or ready tick on a non-empty buffer
// waits for a registered memory read. Reset is synchronous and clears pointers, fills and
// flags; the memories need no clearing. A stalled response holds the next request off.
module uart_buffered_stream_fifos_core #(
   parameter int TX_DEPTH = uart_bsf_pkg::TX_DEPTH_DEFAULT,
   parameter int RX_DEPTH = uart_bsf_pkg::RX_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_line_tx_valid,
   output logic [7:0] rsp_line_tx_byte,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_data,
   output logic       rsp_write_dropped,
   output logic       rsp_rx_nonempty,
   output logic       rsp_overrun_seen,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_TX_LF   = 2'd1;
   localparam logic [1:0] ST_RX_WAIT = 2'd2;
   localparam logic [1:0] ST_TX_WAIT = 2'd3;

   uart_bsf_pkg::byte_type tx_mem [TX_DEPTH];
   uart_bsf_pkg::byte_type rx_mem [RX_DEPTH];

   logic [1:0]       state_ff, state_in;
   logic [TX_AW-1:0] tx_widx_ff, tx_widx_in, tx_ridx_ff, tx_ridx_in;
   logic [TX_CW-1:0] tx_fill_ff, tx_fill_in;
   logic [RX_AW-1:0] rx_widx_ff, rx_widx_in, rx_ridx_ff, rx_ridx_in;
   logic [RX_CW-1:0] rx_fill_ff, rx_fill_in;
   logic             overrun_ff, overrun_in;
   logic             echo_ff;
   logic             drop_ff, drop_in;
   uart_bsf_pkg::byte_type tx_q_ff, rx_q_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             line_tx_valid_ff, line_tx_valid_in;
   logic [7:0]       line_tx_byte_ff, line_tx_byte_in;
   logic             read_valid_ff, read_valid_in;
   logic [7:0]       read_data_ff, read_data_in;
   logic             write_dropped_ff, write_dropped_in;
   logic             rx_nonempty_ff, rx_nonempty_in;
   logic             overrun_seen_ff, overrun_seen_in;

   logic             accept;
   logic             finish;
   logic             tx_full;
   logic             tx_push;
   logic [7:0]       tx_push_byte;
   logic             tx_we, tx_re, rx_we, rx_re;
   logic [7:0]       rx_wbyte;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign tx_full   = (tx_fill_ff == TX_CW'(TX_DEPTH));

   always_comb begin
      state_in         = state_ff;
      tx_widx_in       = tx_widx_ff;
      tx_ridx_in       = tx_ridx_ff;
      tx_fill_in       = tx_fill_ff;
      rx_widx_in       = rx_widx_ff;
      rx_ridx_in       = rx_ridx_ff;
      rx_fill_in       = rx_fill_ff;
      overrun_in       = overrun_ff;
      drop_in          = drop_ff;
      finish           = 1'b0;
      tx_push          = 1'b0;
      tx_push_byte     = req_data;
      tx_we            = 1'b0;
      tx_re            = 1'b0;
      rx_we            = 1'b0;
      rx_re            = 1'b0;
      rx_wbyte         = (req_data == uart_bsf_pkg::CH_CR) ? uart_bsf_pkg::CH_LF : req_data;
      line_tx_valid_in = 1'b0;
      line_tx_byte_in  = 8'd0;
      read_valid_in    = 1'b0;
      read_data_in     = 8'd0;
      write_dropped_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  uart_bsf_pkg::KIND_HOST_WRITE: begin
                     tx_push = 1'b1;
                     if (req_data == uart_bsf_pkg::CH_LF) begin
                        tx_push_byte = uart_bsf_pkg::CH_CR;
                        drop_in      = tx_full;
                        state_in     = ST_TX_LF;
                     end else begin
                        write_dropped_in = tx_full;
                        finish           = 1'b1;
                     end
                  end
                  uart_bsf_pkg::KIND_HOST_READ: begin
                     if (rx_fill_ff != '0) begin
                        rx_re      = 1'b1;
                        rx_fill_in = rx_fill_ff - 1'b1;
                        rx_ridx_in = (rx_ridx_ff == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                         : rx_ridx_ff + 1'b1;
                        state_in   = ST_RX_WAIT;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  uart_bsf_pkg::KIND_LINE_RECV: begin
                     if (rx_fill_ff == RX_CW'(RX_DEPTH)) begin
                        overrun_in = 1'b1;
                     end else begin
                        rx_we      = 1'b1;
                        rx_fill_in = rx_fill_ff + 1'b1;
                        rx_widx_in = (rx_widx_ff == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                         : rx_widx_ff + 1'b1;
                     end
                     if (echo_ff && req_data == uart_bsf_pkg::CH_LF) begin
                        tx_push      = 1'b1;
                        tx_push_byte = uart_bsf_pkg::CH_CR;
                        drop_in      = tx_full;
                        state_in     = ST_TX_LF;
                     end else begin
                        tx_push          = echo_ff;
                        write_dropped_in = echo_ff && tx_full;
                        finish           = 1'b1;
                     end
                  end
                  default: begin
                     if (tx_fill_ff != '0) begin
                        tx_re      = 1'b1;
                        tx_fill_in = tx_fill_ff - 1'b1;
                        tx_ridx_in = (tx_ridx_ff == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                         : tx_ridx_ff + 1'b1;
                        state_in   = ST_TX_WAIT;
                     end else begin
                        finish = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_TX_LF: begin
            tx_push          = 1'b1;
            tx_push_byte     = uart_bsf_pkg::CH_LF;
            write_dropped_in = drop_ff || tx_full;
            finish           = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_RX_WAIT: begin
            read_valid_in = 1'b1;
            read_data_in  = rx_q_ff;
            finish        = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            line_tx_valid_in = 1'b1;
            line_tx_byte_in  = tx_q_ff;
            finish           = 1'b1;
            state_in         = ST_IDLE;
         end
      endcase

      if (tx_push && !tx_full) begin
         tx_we      = 1'b1;
         tx_fill_in = tx_fill_ff + 1'b1;
         tx_widx_in = (tx_widx_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_widx_ff + 1'b1;
      end

      rx_nonempty_in  = (rx_fill_in != '0);
      overrun_seen_in = overrun_in;

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tx_widx_ff   <= '0;
         tx_ridx_ff   <= '0;
         tx_fill_ff   <= '0;
         rx_widx_ff   <= '0;
         rx_ridx_ff   <= '0;
         rx_fill_ff   <= '0;
         overrun_ff   <= 1'b0;
         echo_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tx_widx_ff   <= tx_widx_in;
         tx_ridx_ff   <= tx_ridx_in;
         tx_fill_ff   <= tx_fill_in;
         rx_widx_ff   <= rx_widx_in;
         rx_ridx_ff   <= rx_ridx_in;
         rx_fill_ff   <= rx_fill_in;
         overrun_ff   <= overrun_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            echo_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         line_tx_valid_ff <= line_tx_valid_in;
         line_tx_byte_ff  <= line_tx_byte_in;
         read_valid_ff    <= read_valid_in;
         read_data_ff     <= read_data_in;
         write_dropped_ff <= write_dropped_in;
         rx_nonempty_ff   <= rx_nonempty_in;
         overrun_seen_ff  <= overrun_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_widx_ff] <= tx_push_byte;
      end
      if (tx_re) begin
         tx_q_ff <= tx_mem[tx_ridx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_widx_ff] <= rx_wbyte;
      end
      if (rx_re) begin
         rx_q_ff <= rx_mem[rx_ridx_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_tx_valid = line_tx_valid_ff;
   assign rsp_line_tx_byte  = line_tx_byte_ff;
   assign rsp_read_valid    = read_valid_ff;
   assign rsp_read_data     = read_data_ff;
   assign rsp_write_dropped = write_dropped_ff;
   assign rsp_rx_nonempty   = rx_nonempty_ff;
   assign rsp_overrun_seen  = overrun_seen_ff;

endmodule

// ----- sim/uart_buffered_stream_fifos_core_test.sv -----
`timescale 1ns / 100ps

module uart_buffered_stream_fifos_core_test;

   typedef struct {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rd_valid;
      logic [7:0] rd_data;
      logic       dropped;
      logic       available;
      logic       overrun;
   } uart_response_type;

   class uart_ring_tracker;
      uart_bsf_pkg::byte_type tx_mem [256];
      logic [7:0]             tx_wr;
      logic [8:0]             tx_fill;
      uart_bsf_pkg::byte_type rx_mem [16];
      logic [3:0]             rx_wr;
      logic [4:0]             rx_fill;
      logic                   overrun;
      logic                   echo_on;
      int                     errors;
      uart_response_type      owed_responses [$];

      function new();
         tx_wr   = '0;
         tx_fill = '0;
         rx_wr   = '0;
         rx_fill = '0;
         overrun = 1'b0;
         echo_on = 1'b0;
         errors  = 0;
      endfunction

      function bit tx_push(uart_bsf_pkg::byte_type b);
         if (tx_fill == 9'd256) return 1'b1;
         tx_mem[tx_wr] = b;
         tx_wr++;
         tx_fill++;
         return 1'b0;
      endfunction

      // queue a newline as CR LF
      function bit tx_queue(uart_bsf_pkg::byte_type b);
         bit lost;
         lost = 1'b0;
         if (b == uart_bsf_pkg::CH_LF) lost = tx_push(uart_bsf_pkg::CH_CR);
         if (tx_push(b)) lost = 1'b1;
         return lost;
      endfunction

      function void note_request(logic [1:0] kind, uart_bsf_pkg::byte_type data);
         uart_response_type r;
         logic [7:0] pos;
         r = '{default: '0};
         case (kind)
            uart_bsf_pkg::KIND_HOST_WRITE: begin
               r.dropped = tx_queue(data);
            end
            uart_bsf_pkg::KIND_HOST_READ: begin
               if (rx_fill != 0) begin
                  pos = {4'd0, rx_wr - rx_fill[3:0]};
                  r.rd_valid = 1'b1;
                  r.rd_data  = rx_mem[pos[3:0]];
                  rx_fill--;
               end
            end
            uart_bsf_pkg::KIND_LINE_RECV: begin
               if (echo_on) r.dropped = tx_queue(data);
               if (rx_fill == 5'd16) begin
                  overrun = 1'b1;
               end else begin
                  rx_mem[rx_wr] = (data == uart_bsf_pkg::CH_CR) ? uart_bsf_pkg::CH_LF : data;
                  rx_wr++;
                  rx_fill++;
               end
            end
            uart_bsf_pkg::KIND_TX_READY: begin
               if (tx_fill != 0) begin
                  pos = tx_wr - tx_fill[7:0];
                  r.tx_valid = 1'b1;
                  r.tx_byte  = tx_mem[pos];
                  tx_fill--;
               end
            end
         endcase
         r.available = (rx_fill != 0);
         r.overrun   = overrun;
         owed_responses.push_back(r);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(uart_response_type got);
         uart_response_type want;
         if (owed_responses.size() == 0) begin
            $display("%0t: response beat with none expected, actual tx %b/%h rd %b/%h",
                     $time, got.tx_valid, got.tx_byte, got.rd_valid, got.rd_data);
            errors++;
            return;
         end
         want = owed_responses.pop_front();
         check_field("line_tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
         check_field("line_tx_byte", want.tx_byte, got.tx_byte);
         check_field("read_valid", 8'(want.rd_valid), 8'(got.rd_valid));
         check_field("read_data", want.rd_data, got.rd_data);
         check_field("write_dropped", 8'(want.dropped), 8'(got.dropped));
         check_field("rx_nonempty", 8'(want.available), 8'(got.available));
         check_field("overrun_seen", 8'(want.overrun), 8'(got.overrun));
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = uart_bsf_pkg::KIND_HOST_WRITE;
   logic [7:0] req_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_line_tx_valid;
   logic [7:0] rsp_line_tx_byte;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_data;
   logic       rsp_write_dropped;
   logic       rsp_rx_nonempty;
   logic       rsp_overrun_seen;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;

   uart_ring_tracker tracker;
   bit gaps_on      = 1'b1;
   bit stall_bursts = 1'b1;
   bit hold_long    = 1'b0;

   uart_buffered_stream_fifos_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_tx_valid (rsp_line_tx_valid),
      .rsp_line_tx_byte  (rsp_line_tx_byte),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_write_dropped (rsp_write_dropped),
      .rsp_rx_nonempty   (rsp_rx_nonempty),
      .rsp_overrun_seen  (rsp_overrun_seen),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      uart_response_type got;
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_request(req_kind, req_data);
         if (rsp_valid && !rsp_stall) begin
            got.tx_valid  = rsp_line_tx_valid;
            got.tx_byte   = rsp_line_tx_byte;
            got.rd_valid  = rsp_read_valid;
            got.rd_data   = rsp_read_data;
            got.dropped   = rsp_write_dropped;
            got.available = rsp_rx_nonempty;
            got.overrun   = rsp_overrun_seen;
            tracker.check_response(got);
         end
      end
   end

   // response side back-pressure
   initial begin
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (stall_bursts && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_beat(logic [1:0] kind, uart_bsf_pkg::byte_type data);
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_data  <= data;
      do @(posedge clock); while (req_stall);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_echo(logic on);
      csr_write_data   <= on;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.echo_on = on;
   endtask

   task automatic send_random(int count);
      int                     bias;
      int                     pick;
      logic [1:0]             kind;
      uart_bsf_pkg::byte_type data;
      bias = 2;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) bias = $urandom_range(0, 2);
         pick = $urandom_range(0, 9);
         if (bias == 0)
            kind = (pick < 4) ? uart_bsf_pkg::KIND_HOST_WRITE :
                   (pick < 8) ? uart_bsf_pkg::KIND_LINE_RECV :
                   (pick == 8) ? uart_bsf_pkg::KIND_HOST_READ : uart_bsf_pkg::KIND_TX_READY;
         else if (bias == 1)
            kind = (pick < 4) ? uart_bsf_pkg::KIND_HOST_READ :
                   (pick < 8) ? uart_bsf_pkg::KIND_TX_READY :
                   (pick == 8) ? uart_bsf_pkg::KIND_HOST_WRITE : uart_bsf_pkg::KIND_LINE_RECV;
         else
            kind = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 7))
            0:       data = uart_bsf_pkg::CH_LF;
            1:       data = uart_bsf_pkg::CH_CR;
            default: data = 8'($urandom_range(0, 255));
         endcase
         send_beat(kind, data);
      end
   endtask

   initial begin
      int                     room;
      uart_bsf_pkg::byte_type fill_byte;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_echo(1'b0);

      send_beat(uart_bsf_pkg::KIND_HOST_READ, 8'hFF);
      send_beat(uart_bsf_pkg::KIND_TX_READY, 8'hFF);
      send_beat(uart_bsf_pkg::KIND_HOST_WRITE, 8'h00);
      send_beat(uart_bsf_pkg::KIND_HOST_WRITE, 8'hFF);
      send_beat(uart_bsf_pkg::KIND_HOST_WRITE, uart_bsf_pkg::CH_LF);
      send_beat(uart_bsf_pkg::KIND_HOST_WRITE, uart_bsf_pkg::CH_CR);
      repeat (6) send_beat(uart_bsf_pkg::KIND_TX_READY, 8'h00);
      send_beat(uart_bsf_pkg::KIND_LINE_RECV, uart_bsf_pkg::CH_CR);
      send_beat(uart_bsf_pkg::KIND_LINE_RECV, 8'h00);
      send_beat(uart_bsf_pkg::KIND_LINE_RECV, 8'hFF);
      send_beat(uart_bsf_pkg::KIND_LINE_RECV, uart_bsf_pkg::CH_LF);
      repeat (5) send_beat(uart_bsf_pkg::KIND_HOST_READ, 8'h00);
      drain_all();

      set_echo(1'b1);
      send_beat(uart_bsf_pkg::KIND_LINE_RECV, uart_bsf_pkg::CH_CR);
      send_beat(uart_bsf_pkg::KIND_LINE_RECV, uart_bsf_pkg::CH_LF);
      send_beat(uart_bsf_pkg::KIND_LINE_RECV, 8'hA5);
      repeat (5) send_beat(uart_bsf_pkg::KIND_TX_READY, 8'h00);
      repeat (3) send_beat(uart_bsf_pkg::KIND_HOST_READ, 8'h00);
      drain_all();

      // fill transmit side to one short of full, then split a newline
      room = 255 - int'(tracker.tx_fill);
      repeat (room / 2) send_beat(uart_bsf_pkg::KIND_HOST_WRITE, uart_bsf_pkg::CH_LF);
      if (room % 2 == 1) begin
         fill_byte = 8'($urandom_range(0, 255));
         if (fill_byte == uart_bsf_pkg::CH_LF) fill_byte = 8'h41;
         send_beat(uart_bsf_pkg::KIND_HOST_WRITE, fill_byte);
      end
      send_beat(uart_bsf_pkg::KIND_HOST_WRITE, uart_bsf_pkg::CH_LF);
      send_beat(uart_bsf_pkg::KIND_HOST_WRITE, 8'h55);
      drain_all();
      room = 17 - int'(tracker.rx_fill);
      repeat (room) send_beat(uart_bsf_pkg::KIND_LINE_RECV, 8'($urandom_range(0, 255)));
      repeat (257) send_beat(uart_bsf_pkg::KIND_TX_READY, 8'h00);
      repeat (18) send_beat(uart_bsf_pkg::KIND_HOST_READ, 8'h00);
      drain_all();

      for (int phase = 0; phase < 4; phase++) begin
         set_echo(phase == 1 || phase == 2);
         if (phase == 1) hold_long = 1'b1;
         if (phase == 3) begin
            gaps_on      = 1'b0;
            stall_bursts = 1'b0;
         end
         send_random(25);
         drain_all();
      end

      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/uart_bsf_pkg.sv
rtl/core/uart_buffered_stream_fifos_core.sv
sim/uart_buffered_stream_fifos_core_test.sv
